// ===== rtl/fcmt_pkg.sv =====
// ============================================================================
// Fixed-capacity multiset table package
// Shared sizes, command codes and request/response types for the table.
// ============================================================================
package fcmt_pkg;

  // Table geometry.
  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // Fixed widths of the channel fields.
  localparam int CMD_W      = 2;
  localparam int ITEM_W     = 32;
  localparam int OUT_CNT_W  = 5;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       count_t;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // One request on the input channel.
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ITEM_W-1:0] item_value;
  } in_req_t;

  // One response on the result channel.
  typedef struct packed {
    logic                 accepted;
    logic                 found;
    logic [OUT_CNT_W-1:0] match_count;
    logic [OUT_CNT_W-1:0] entry_count;
    logic                 is_empty;
  } out_rsp_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic in_range;  // slot holds a live entry
    logic is_last;   // slot holds the last live entry
    logic scan_en;   // capture compare results this cycle
    logic wr_en;     // load the write data into the slot
  } cell_ctl_t;

endpackage

// ===== rtl/fcmt_cell.sv =====
// ============================================================================
// Multiset table cell
// One slot of the table: stores an entry, compares it against the broadcast
// key and passes the first-match and last-entry chains to its neighbors.
// ============================================================================
module fcmt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  fcmt_pkg::cell_ctl_t ctl,
  input  fcmt_pkg::value_t  key,
  input  fcmt_pkg::value_t  wr_data,
  input  logic              seen_in,
  input  fcmt_pkg::value_t  tail_in,
  output logic              seen_out,
  output fcmt_pkg::value_t  tail_out,
  output logic              hit,
  output logic              first
);
  import fcmt_pkg::*;

  value_t entry_r;
  logic   hit_r;
  logic   first_r;
  logic   match;

  // Compare only live slots against the key.
  assign match    = ctl.in_range && (entry_r == key);

  // A match in this slot or anywhere below it is handed upward.
  assign seen_out = seen_in | match;

  // The last live entry travels downward toward slot zero.
  assign tail_out = ctl.is_last ? entry_r : tail_in;

  assign hit   = hit_r;
  assign first = first_r;

  // Capture the compare results during the scan cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      first_r <= 1'b0;
    end else if (ctl.scan_en) begin
      hit_r   <= match;
      first_r <= match & ~seen_in;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      entry_r <= wr_data;
    end
  end

endmodule

// ===== rtl/fixed_capacity_multiset_table.sv =====
// ============================================================================
// Fixed-capacity multiset table
// Unordered bag of values held in a row of compare cells, with add, remove,
// query and clear requests.
// ============================================================================
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   It carries a command (add, remove, query, clear) and a value.
//   Each request yields one response on out_rsp, marked by out_valid for
//   exactly one cycle; the receiver cannot hold it off.
// Timing:
//   In the scan state the key is broadcast to all cells, which compare in
//   parallel and latch their hit and first-match flags while the last entry
//   is carried down the cell chain. In the update state the hits are counted,
//   the slot is written for add or remove and the response and out_valid
//   are registered. busy is high only in the compare cycle, so a new request
//   can be taken while the one before it is in its update cycle.
// Reset:
//   rst_n clears the entry count and the sequencer; stored values are left
//   as they are and are never read until written again.
// ============================================================================
module fixed_capacity_multiset_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  fcmt_pkg::in_req_t  in_req,
  output logic               out_valid,
  output fcmt_pkg::out_rsp_t out_rsp
);
  import fcmt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  state_t   state_r;
  cmd_t     cmd_r;
  value_t   key_r;
  value_t   tail_r;
  count_t   count_r;
  count_t   count_nxt;
  logic     out_valid_r;
  out_rsp_t out_rsp_r;
  out_rsp_t rsp_nxt;

  logic                  take;
  logic                  found;
  count_t                hit_count;
  logic                  add_ok;
  logic                  rem_ok;
  value_t                wr_data;
  logic   [CAPACITY-1:0] hit_vec;
  logic   [CAPACITY-1:0] first_vec;
  logic   [CAPACITY:0]   seen_chain;
  value_t                tail_chain [CAPACITY+1];
  cell_ctl_t             ctl_vec    [CAPACITY];

  assign busy      = (state_r == ST_SCAN);
  assign take      = start && !busy;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Chain ends.
  assign seen_chain[0]        = 1'b0;
  assign tail_chain[CAPACITY] = '0;

  // Results of the compare cycle.
  assign found     = |hit_vec;
  assign hit_count = CNT_W'($countones(hit_vec));
  assign add_ok    = (cmd_r == CMD_ADD) && (count_r < CNT_W'(CAPACITY));
  assign rem_ok    = (cmd_r == CMD_REMOVE) && found;
  assign wr_data   = (cmd_r == CMD_ADD) ? key_r : tail_r;

  // Row of table cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      ctl_vec[i].in_range = (count_r > CNT_W'(i));
      ctl_vec[i].is_last  = (count_r == CNT_W'(i + 1));
      ctl_vec[i].scan_en  = (state_r == ST_SCAN);
      ctl_vec[i].wr_en    = (state_r == ST_UPDATE) &&
                            ((add_ok && (count_r == CNT_W'(i))) ||
                             (rem_ok && first_vec[i]));
    end

    fcmt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl_vec[i]),
      .key      (key_r),
      .wr_data  (wr_data),
      .seen_in  (seen_chain[i]),
      .tail_in  (tail_chain[i+1]),
      .seen_out (seen_chain[i+1]),
      .tail_out (tail_chain[i]),
      .hit      (hit_vec[i]),
      .first    (first_vec[i])
    );
  end

  // Next count and response for the request in its update cycle.
  always_comb begin
    count_nxt           = count_r;
    rsp_nxt.accepted    = 1'b1;
    rsp_nxt.found       = found;
    rsp_nxt.match_count = OUT_CNT_W'(hit_count);
    case (cmd_r)
      CMD_ADD: begin
        if (add_ok) begin
          count_nxt = count_r + 1'b1;
        end else begin
          rsp_nxt.accepted = 1'b0;
        end
      end
      CMD_REMOVE: begin
        if (rem_ok) begin
          count_nxt = count_r - 1'b1;
        end else begin
          rsp_nxt.accepted = 1'b0;
        end
      end
      CMD_QUERY: begin
        count_nxt = count_r;
      end
      CMD_CLEAR: begin
        count_nxt           = '0;
        rsp_nxt.found       = 1'b0;
        rsp_nxt.match_count = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    rsp_nxt.entry_count = OUT_CNT_W'(count_nxt);
    rsp_nxt.is_empty    = (count_nxt == '0);
  end

  // Sequencer, request capture and registered response.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (take) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          state_r <= ST_UPDATE;
          tail_r  <= tail_chain[0];
        end
        ST_UPDATE: begin
          count_r     <= count_nxt;
          out_valid_r <= 1'b1;
          out_rsp_r   <= rsp_nxt;
          state_r     <= take ? ST_SCAN : ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (take) begin
        cmd_r <= cmd_t'(in_req.command);
        key_r <= in_req.item_value[VALUE_WIDTH-1:0];
      end
    end
  end

  // The entry count never passes the capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // At most one cell claims the first match.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first_vec))
    else $error("more than one first-match cell");

  // Every taken request is followed by its response strobe.
  assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##3 out_valid)
    else $error("response missing two cycles after request");

  // A response follows only an update cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_UPDATE))
    else $error("response without update cycle");

  // A first-match flag always marks a hit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (first_vec & ~hit_vec) == '0)
    else $error("first-match flag without hit");

endmodule
